### hdl/xml_entity_unescape_macros.svh
// ---------------------------------------------------------------------------
// XML entity unescape assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPE_MACROS_SVH
`define XML_ENTITY_UNESCAPE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define XEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define XEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define XEU_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/xeu_pkg.sv
// ---------------------------------------------------------------------------
// xeu_pkg
// Types, entity tables and codes shared by the entity unescape block.
// ---------------------------------------------------------------------------
package xeu_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int ENT_COUNT  = 5;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  localparam logic [7:0] AMP_CHAR = 8'h26;

  // entity names without the leading ampersand, zero padded
  localparam logic [7:0] ENT_NAME [ENT_COUNT][HOLD_DEPTH] = '{
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // amp;
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // lt;
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // gt;
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // quot;
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}   // apos;
  };
  localparam logic [2:0] ENT_LEN  [ENT_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
  localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xeu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } xeu_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } xeu_qstat_t;

  typedef enum logic [1:0] {
    FS_SCAN,
    FS_REPLAY,
    FS_FLUSH
  } xeu_fstate_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT_BYTE,
    ACT_EMIT_ENT,
    ACT_OPEN,
    ACT_APPEND,
    ACT_POP
  } xeu_act_t;

endpackage

### hdl/xeu_fifo.sv
// ---------------------------------------------------------------------------
// xeu_fifo
// Short byte queue between the classifier and the output stage.
// ---------------------------------------------------------------------------
module xeu_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xeu_pkg::xeu_out_t push_data,
  input  logic              pop,
  output xeu_pkg::xeu_out_t head,
  output xeu_pkg::xeu_qstat_t stat
);
  import xeu_pkg::*;

  xeu_out_t         mem [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QCW-1:0]   count;

  assign head       = mem[rptr];
  assign stat.full  = (count == QCW'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

### hdl/xeu_front.sv
// ---------------------------------------------------------------------------
// xeu_front
// Takes input bytes, tracks the held entity prefix, queues output bytes.
// ---------------------------------------------------------------------------
module xeu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  xeu_pkg::xeu_in_t    item,
  output logic                push,
  output xeu_pkg::xeu_out_t   push_data,
  input  xeu_pkg::xeu_qstat_t qstat
);
  import xeu_pkg::*;

  xeu_fstate_t          state;
  xeu_fstate_t          state_next;
  logic                 cur_valid;
  xeu_in_t              cur;
  logic [7:0]           held [HOLD_DEPTH];
  logic [2:0]           hcnt;
  logic [ENT_COUNT-1:0] cand;

  logic [2:0]           k;
  logic [ENT_COUNT-1:0] hit;
  logic [ENT_COUNT-1:0] full_hit;
  logic                 partial;
  logic [7:0]           ent_byte;
  xeu_act_t             act;
  logic                 needs_push;
  logic                 go;
  logic                 done;
  logic                 last_pop;

  // match the current byte against every live entity candidate
  always_comb begin
    k        = hcnt - 3'd1;
    hit      = '0;
    full_hit = '0;
    ent_byte = '0;
    for (int e = ENT_COUNT - 1; e >= 0; e--) begin
      hit[e] = cand[e] && (k < ENT_LEN[e]) && (ENT_NAME[e][k] == cur.in_byte);
      full_hit[e] = hit[e] && ((k + 3'd1) == ENT_LEN[e]);
      if (full_hit[e]) begin
        ent_byte = ENT_CHAR[e];
      end
    end
    partial = |(hit & ~full_hit);
  end

  always_comb begin
    act = ACT_NONE;
    if (cur_valid) begin
      unique case (state)
        FS_SCAN: begin
          if (hcnt == '0) begin
            act = (cur.in_byte == AMP_CHAR) ? ACT_OPEN : ACT_EMIT_BYTE;
          end else if (|full_hit) begin
            act = ACT_EMIT_ENT;
          end else if (partial && (hcnt < 3'(HOLD_DEPTH))) begin
            act = ACT_APPEND;
          end else begin
            act = ACT_POP;
          end
        end
        FS_REPLAY, FS_FLUSH: act = ACT_POP;
        default: act = ACT_NONE;
      endcase
    end
  end

  assign needs_push = act inside {ACT_EMIT_BYTE, ACT_EMIT_ENT, ACT_POP};
  assign go         = (act != ACT_NONE) && !(needs_push && qstat.full);
  assign last_pop   = (hcnt == 3'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_SCAN: begin
        if (go) begin
          if (act == ACT_POP) begin
            state_next = last_pop ? FS_SCAN : FS_REPLAY;
          end else if ((act == ACT_OPEN || act == ACT_APPEND) && cur.in_last) begin
            state_next = FS_FLUSH;
          end
        end
      end
      FS_REPLAY, FS_FLUSH: begin
        if (go && last_pop) begin
          state_next = FS_SCAN;
        end
      end
      default: state_next = FS_SCAN;
    endcase
  end

  // outputs
  always_comb begin
    push               = go && needs_push;
    push_data.out_byte = held[0];
    push_data.out_last = 1'b0;
    done               = 1'b0;
    unique case (act)
      ACT_EMIT_BYTE: begin
        push_data.out_byte = cur.in_byte;
        push_data.out_last = cur.in_last;
        done               = go;
      end
      ACT_EMIT_ENT: begin
        push_data.out_byte = ent_byte;
        push_data.out_last = cur.in_last;
        done               = go;
      end
      ACT_OPEN, ACT_APPEND: begin
        done = go && !cur.in_last;
      end
      ACT_POP: begin
        push_data.out_last = (state == FS_FLUSH) && last_pop;
        done               = go && (state == FS_FLUSH) && last_pop;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  assign item_stall = cur_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_SCAN;
      cur_valid <= 1'b0;
      hcnt      <= '0;
    end else begin
      state <= state_next;
      if (!item_stall) begin
        cur_valid <= item_valid;
      end
      if (go) begin
        case (act)
          ACT_OPEN:     hcnt <= 3'd1;
          ACT_APPEND:   hcnt <= hcnt + 3'd1;
          ACT_EMIT_ENT: hcnt <= '0;
          ACT_POP:      hcnt <= hcnt - 3'd1;
          default:      hcnt <= hcnt;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      cur <= item;
    end
    if (go) begin
      case (act)
        ACT_OPEN: begin
          held[0] <= cur.in_byte;
          cand    <= '1;
        end
        ACT_APPEND: begin
          held[hcnt] <= cur.in_byte;
          cand       <= hit & ~full_hit;
        end
        ACT_POP: begin
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            held[i] <= held[i+1];
          end
        end
        default: begin
          cand <= cand;
        end
      endcase
    end
  end

endmodule

### hdl/xeu_back.sv
// ---------------------------------------------------------------------------
// xeu_back
// Output register: drains the queue onto the result channel.
// ---------------------------------------------------------------------------
module xeu_back (
  input  logic                clk,
  input  logic                rst,
  input  xeu_pkg::xeu_out_t   head,
  input  xeu_pkg::xeu_qstat_t qstat,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output xeu_pkg::xeu_out_t   result
);
  import xeu_pkg::*;

  assign pop = !qstat.empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= head;
    end
  end

endmodule

### hdl/xml_entity_unescape.sv
// Path: a plain byte passes the item register, the queue and the output register.
// Throughput: one byte per cycle while the queue has room; input stalls while a broken
//   prefix replays and while a last byte flushes the hold (single front sequencer).
// Result stalls back up through a four-entry queue, then stall the item channel.
// Reset (rst, synchronous) empties the queue and the hold; no clearing pass.
// ---------------------------------------------------------------------------
// xml_entity_unescape
// Predefined XML entity decoder: &amp; &lt; &gt; &quot; &apos; become one byte.
// ---------------------------------------------------------------------------
module xml_entity_unescape (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  xeu_pkg::xeu_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output xeu_pkg::xeu_out_t result
);
  import xeu_pkg::*;

  // Front to queue: one output byte per cycle at most.
  logic       push;
  xeu_out_t   push_data;
  // Queue to back: head entry and fill status.
  logic       pop;
  xeu_out_t   head;
  xeu_qstat_t qstat;

  // Front: holds the current transaction, tracks the ampersand and name
  // prefix, and decides per cycle whether to emit the byte, the entity
  // character, a replayed held byte, or to extend the hold.
  xeu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .qstat      (qstat)
  );

  // Queue decouples classification from the result handshake.
  xeu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // Back: output register, refilled whenever it is empty or being taken.
  xeu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### hdl/xeu_checker.sv
// ---------------------------------------------------------------------------
// xeu_checker
// Port-level checks for the entity unescape block, bound to the top level.
// ---------------------------------------------------------------------------
`include "xml_entity_unescape_macros.svh"

module xeu_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input xeu_pkg::xeu_in_t  item,
  input logic              result_valid,
  input logic              result_stall,
  input xeu_pkg::xeu_out_t result
);
  import xeu_pkg::*;

  logic       in_last_acc;
  logic       out_last_acc;
  logic [3:0] pending;

  assign in_last_acc  = item_valid && !item_stall && item.in_last;
  assign out_last_acc = result_valid && !result_stall && result.out_last;

  // strings whose last byte went in but whose final result is not yet out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_last_acc && !out_last_acc) begin
      pending <= pending + 4'd1;
    end else if (out_last_acc && !in_last_acc) begin
      pending <= pending - 4'd1;
    end
  end

  `XEU_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")
  `XEU_ASSERT_RESET(a_reset_result, clk, rst, !result_valid, "result valid after reset")
  `XEU_ASSERT_RESET(a_reset_ready, clk, rst, !item_stall, "item channel stalled after reset")
  `XEU_ASSERT_NOW(a_last_order, clk, rst, out_last_acc, pending != 4'd0, "last result without a last item")

endmodule

bind xml_entity_unescape xeu_checker u_xeu_checker (.*);

### bench/xml_entity_unescape_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xml_entity_unescape_tb
// Self-checking bench for the predefined XML entity decoder. Byte strings go
// in on the item channel under random gaps and result stalls, and every
// result transaction is compared with a cycle-free model of the decoder.
// ---------------------------------------------------------------------------

class entity_scoreboard;
  localparam logic [7:0] AMP          = 8'h26;
  localparam int         HOLD_MAX     = 5;
  localparam int         ENTITY_COUNT = 5;
  localparam int         REPORT_MAX   = 10;

  logic [7:0]        held [HOLD_MAX];
  int                held_n;
  xeu_pkg::xeu_out_t step_q[$];
  xeu_pkg::xeu_out_t expected_q[$];
  int                errors;
  int                checked;
  int                decoded;
  int                max_step;

  function new();
    held_n   = 0;
    errors   = 0;
    checked  = 0;
    decoded  = 0;
    max_step = 0;
  endfunction

  // entity names without the ampersand, and the byte each one becomes
  static function string name_of(int e);
    case (e)
      0:       return "amp;";
      1:       return "lt;";
      2:       return "gt;";
      3:       return "quot;";
      default: return "apos;";
    endcase
  endfunction

  static function logic [7:0] char_of(int e);
    case (e)
      0:       return 8'h26;
      1:       return 8'h3C;
      2:       return 8'h3E;
      3:       return 8'h22;
      default: return 8'h27;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void emit(logic [7:0] b);
    xeu_pkg::xeu_out_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    step_q.push_back(r);
  endfunction

  function void release_held();
    for (int i = 0; i < held_n; i++) emit(held[i]);
    held_n = 0;
  endfunction

  function void take_plain(logic [7:0] b);
    if (b == AMP) begin
      held[0] = b;
      held_n  = 1;
    end else begin
      emit(b);
    end
  endfunction

  // one accepted input transaction -> zero to six expected result bytes
  function void note_item(xeu_pkg::xeu_in_t t);
    logic [7:0]        b;
    string             nm;
    int                k;
    int                hit;
    bit                partial;
    bit                same;
    xeu_pkg::xeu_out_t tail;
    b = t.in_byte;
    step_q.delete();
    if (held_n == 0) begin
      take_plain(b);
    end else begin
      k       = held_n - 1;
      hit     = -1;
      partial = 1'b0;
      for (int e = 0; e < ENTITY_COUNT; e++) begin
        nm = name_of(e);
        if (k < nm.len() && nm[k] == b) begin
          same = 1'b1;
          for (int i = 0; i < k; i++) if (held[i + 1] != nm[i]) same = 1'b0;
          if (same) begin
            if (k + 1 == nm.len()) hit = e;
            else partial = 1'b1;
          end
        end
      end
      if (hit >= 0) begin
        held_n = 0;
        emit(char_of(hit));
        decoded++;
      end else if (partial && held_n < HOLD_MAX) begin
        held[held_n] = b;
        held_n++;
      end else begin
        release_held();
        take_plain(b);
      end
    end
    if (t.in_last) begin
      release_held();
      if (step_q.size() > 0) begin
        tail = step_q.pop_back();
        tail.out_last = 1'b1;
        step_q.push_back(tail);
      end
    end
    if (step_q.size() > max_step) max_step = step_q.size();
    foreach (step_q[j]) expected_q.push_back(step_q[j]);
  endfunction

  function void flag(string what, int want, int got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("ERROR result %0d %s: expected %0h, got %0h", checked, what, want, got);
  endfunction

  function void check_result(xeu_pkg::xeu_out_t got);
    xeu_pkg::xeu_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("ERROR unexpected result: byte %02h last %0b", got.out_byte, got.out_last);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte) flag("out_byte", want.out_byte, got.out_byte);
    if (got.out_last !== want.out_last) flag("out_last", want.out_last, got.out_last);
    checked++;
  endfunction

  function void finish_check();
    if (expected_q.size() != 0) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("ERROR %0d result bytes never arrived", expected_q.size());
    end
  endfunction
endclass

module xml_entity_unescape_tb;
  import xeu_pkg::*;

  localparam int         CLK_HALF     = 10;
  localparam int         RESET_CYCLES = 8;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         CYCLE_LIMIT  = 800000;
  localparam int         LONG_HOLD    = 300;
  localparam int         WARMUP_ITEMS = 100;
  localparam int         SQUEEZE_ITEMS = 60;
  localparam int         TAIL_ITEMS   = 120;
  localparam logic [7:0] AMP_BYTE     = 8'h26;

  // what a random string is built from
  typedef enum int {
    TOK_ENTITY,    // complete entity reference
    TOK_PREFIX,    // ampersand plus a cut-short name
    TOK_NAMECHAR,  // a letter or mark that shows up in entity references
    TOK_ANYBYTE    // any byte value
  } token_kind_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     item_valid;
  logic     item_stall;
  xeu_in_t  item;
  logic     result_valid;
  logic     result_stall;
  xeu_out_t result;

  entity_scoreboard sb = new();

  logic [7:0] text_q[$];     // string being built, sent one byte per transaction
  int         hold_len = 0;  // receiver hold-off request, in cycles
  bit         gaps_on = 1'b1;
  bit         gaps_allowed = 1'b1;
  int         cycles = 0;
  int         items_sent = 0;
  int         texts_sent = 0;

  xml_entity_unescape u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Both channels are sampled here, in the active region right after the
  // edge, so the values seen are the ones the DUT saw at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result bytes outstanding", cycles,
               sb.pending());
      $display("xml_entity_unescape: mismatch");
      $finish;
    end
  end

  // mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: quiet stretches, choppy stretches, stall bursts, and a long
  // hold-off whenever the stimulus asks for one.
  initial begin : result_side
    int n;
    int r;
    forever begin
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(4, 40)) @(posedge clk);
        end else if (r < 85) begin
          repeat ($urandom_range(4, 30)) begin
            result_stall <= ($urandom_range(0, 2) == 0);
            @(posedge clk);
          end
        end else begin
          result_stall <= 1'b1;
          repeat (gap_len() + 1) @(posedge clk);
        end
      end
    end
  end

  // One input transaction. Valid stays high after acceptance until the next
  // call decides whether to idle first, so back-to-back bytes never drop it.
  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{in_byte: b, in_last: l};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // the whole string goes out, last flag on its final byte
  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  // Mostly well-formed text: entities, cut-short names and name letters,
  // so holds of every depth open, complete and break. Noise strings are raw
  // bytes and cover every bit of in_byte.
  task automatic build_text(input bit noise);
    token_kind_t kind;
    int          r;
    int          cut;
    string       nm;
    string       alpha;
    alpha = "amplgtquos;&";
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (noise)       kind = TOK_ANYBYTE;
      else if (r < 45) kind = TOK_ENTITY;
      else if (r < 65) kind = TOK_PREFIX;
      else if (r < 85) kind = TOK_NAMECHAR;
      else             kind = TOK_ANYBYTE;
      nm = sb.name_of($urandom_range(0, 4));
      case (kind)
        TOK_ENTITY: begin
          text_q.push_back(AMP_BYTE);
          push_str(nm);
        end
        TOK_PREFIX: begin
          cut = $urandom_range(0, nm.len() - 1);
          text_q.push_back(AMP_BYTE);
          for (int i = 0; i < cut; i++) text_q.push_back(nm[i]);
        end
        TOK_NAMECHAR: text_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        default:      text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_texts(input int quota);
    int stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if (gaps_allowed) gaps_on = ($urandom_range(0, 3) != 0);
      build_text($urandom_range(0, 7) == 0);
      send_text();
    end
  endtask

  // the byte accepted at the edge just taken is noted at that same edge,
  // so the count is only trusted from the next edge on
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: a five-byte hold broken by an ampersand that opens the next
    // entity, the other four entities, an entity on the last byte, a zero byte, a
    // hold flushed by the last byte, and a lone ampersand as last byte.
    push_str("&quot&apos;&amp;&gt;&lt;");
    send_text();
    text_q.push_back(8'h00);
    push_str("&a");
    send_text();
    push_str("&");
    send_text();

    run_texts(WARMUP_ITEMS);

    // Squeeze: the result side holds off for a long stretch while bytes keep
    // coming with no gaps, so the output queue fills and item_stall rises.
    item_valid <= 1'b0;
    hold_len = LONG_HOLD;
    while (hold_len != 0) @(posedge clk);
    gaps_allowed = 1'b0;
    gaps_on      = 1'b0;
    run_texts(SQUEEZE_ITEMS);
    gaps_allowed = 1'b1;

    // sender pause until the block has handed back everything
    wait_drained();
    repeat ($urandom_range(1, 8)) @(posedge clk);

    run_texts(TAIL_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("sent %0d bytes in %0d strings, checked %0d result bytes, %0d entities decoded",
             items_sent, texts_sent, sb.checked, sb.decoded);
    $display("most results from one byte: %0d; long result hold-off and drain pause included",
             sb.max_step);
    if (sb.errors == 0) begin
      $display("xml_entity_unescape: match");
    end else begin
      $display("%0d errors", sb.errors);
      $display("xml_entity_unescape: mismatch");
    end
    $finish;
  end
endmodule
